### design/tlmh64_pkg.sv
// Shared types and constants of the two-lane multiply hash block.
// Holds the hash constants, the multiplier request and status structs
// and the byte reversal helper. No dependencies.
package tlmh64_pkg;

    localparam int WORD_W    = 64;
    localparam int HALF_W    = 32;
    localparam int PROD_W    = 128;
    localparam int LEN_W     = 32;
    localparam int COUNT_W   = 5;
    localparam int NIBBLE_W  = 4;
    localparam int IN_DATA_W = 168;   // 165 field bits filled up to whole bytes

    localparam logic [WORD_W-1:0] HASH_K1 = 64'h1591_aefa_5e7e_5a17;
    localparam logic [WORD_W-1:0] HASH_K2 = 64'h2bb6_8635_66c4_e761;

    // request into the shared multiplier
    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
    } mul_req_t;

    // status back from the shared multiplier
    typedef struct packed {
        logic busy;
        logic done;
    } mul_stat_t;

    function automatic logic [WORD_W-1:0] byte_rev(input logic [WORD_W-1:0] x);
        logic [WORD_W-1:0] r;
        r = '0;
        for (int i = 0; i < WORD_W / 8; i++)
        begin
            r[8*i +: 8] = x[WORD_W-8-8*i +: 8];
        end
        return r;
    endfunction

endpackage

### design/two_lane_multiply_hash64.sv
// Top level of the two-lane multiply hash: chunk sequencer and lane state.
// Instantiates tlmh64_mul and tlmh64_fold; depends on tlmh64_pkg.
//
// Usage: a message enters as 16-byte chunks on the s_ stream. s_tuser marks the
// first chunk (lanes are seeded from its length), s_tlast marks the final one.
// Chunks that arrive while no message is open and without s_tuser are dropped.
// Each last chunk of an open message yields one 64-bit hash on the m_ stream.
// All lane products run through one iterative 64x64 multiplier made of a
// single 32x32 multiplier. A full chunk takes two lane products; a short or
// empty chunk takes none. A last chunk adds 2 finish rounds of two products
// each, and then the output register is loaded.
// s_tready is high only while the sequencer is idle.
// The result sits in an output register; if m_tready stays low the next
// message still runs up to its own result, which waits until the register
// frees. Reset clears both lanes, closes any open message and empties the
// output register.
module two_lane_multiply_hash64 (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // message_length, data_low, data_high, byte_count, 3 zero bits
    input  logic [tlmh64_pkg::IN_DATA_W-1:0] s_tdata,
    // first_chunk
    input  logic         s_tuser,
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    // hash_value
    output logic [63:0]  m_tdata
);
    import tlmh64_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_CA_GO   = 4'd1;
    localparam logic [3:0] S_CA_WAIT = 4'd2;
    localparam logic [3:0] S_CB_GO   = 4'd3;
    localparam logic [3:0] S_CB_WAIT = 4'd4;
    localparam logic [3:0] S_FA_GO   = 4'd5;
    localparam logic [3:0] S_FA_WAIT = 4'd6;
    localparam logic [3:0] S_FB_GO   = 4'd7;
    localparam logic [3:0] S_FB_WAIT = 4'd8;
    localparam logic [3:0] S_OUT     = 4'd9;

    logic [3:0]        state_reg, state_next;
    logic [WORD_W-1:0] lane_a_reg, lane_a_next;
    logic [WORD_W-1:0] lane_b_reg, lane_b_next;
    logic              open_reg, open_next;
    logic              last_reg, last_next;
    logic              round_reg, round_next;
    logic [WORD_W-1:0] data_lo_reg, data_lo_next;
    logic [WORD_W-1:0] data_hi_reg, data_hi_next;
    logic [WORD_W-1:0] tmp_lo_reg, tmp_lo_next;
    logic [WORD_W-1:0] tmp_hi_reg, tmp_hi_next;
    logic              m_valid_reg, m_valid_next;
    logic [WORD_W-1:0] m_data_reg, m_data_next;

    logic [LEN_W-1:0]   in_length;
    logic [WORD_W-1:0]  in_low;
    logic [WORD_W-1:0]  in_high;
    logic [COUNT_W-1:0] in_count;
    logic               accept;
    logic [WORD_W-1:0]  seed_a;
    logic [WORD_W-1:0]  seed_b;
    logic               msg_live;
    logic [WORD_W-1:0]  fold_word;
    logic [WORD_W-1:0]  finish_b;
    logic               out_free;

    mul_req_t          mul_req;
    mul_stat_t         mul_stat;
    logic [PROD_W-1:0] mul_product;

    // unpack the input transfer
    assign in_length = s_tdata[LEN_W-1:0];
    assign in_low    = s_tdata[LEN_W +: WORD_W];
    assign in_high   = s_tdata[LEN_W+WORD_W +: WORD_W];
    assign in_count  = s_tdata[LEN_W+2*WORD_W +: COUNT_W];

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // tail word of a short last chunk
    tlmh64_fold u_fold (
        .data_low  (in_low),
        .data_high (in_high),
        .count     (in_count[NIBBLE_W-1:0]),
        .word      (fold_word)
    );

    // shared multiplier
    tlmh64_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mul_req),
        .stat    (mul_stat),
        .product (mul_product)
    );

    // multiplier operands by sequencer step
    always_comb
    begin
        mul_req.start = 1'b0;
        mul_req.a     = lane_a_reg;
        mul_req.b     = HASH_K1;
        unique case (state_reg)
            S_CA_GO:
            begin
                mul_req.start = 1'b1;
                mul_req.a     = lane_a_reg ^ data_lo_reg;
                mul_req.b     = HASH_K1;
            end
            S_CB_GO:
            begin
                mul_req.start = 1'b1;
                mul_req.a     = lane_b_reg ^ data_hi_reg;
                mul_req.b     = HASH_K2;
            end
            S_FA_GO:
            begin
                mul_req.start = 1'b1;
                mul_req.a     = lane_a_reg;
                mul_req.b     = HASH_K1;
            end
            S_FB_GO:
            begin
                mul_req.start = 1'b1;
                mul_req.a     = lane_b_reg;
                mul_req.b     = HASH_K2;
            end
            default:
            begin
                mul_req.start = 1'b0;
            end
        endcase
    end

    // seeding and finish-round sum
    always_comb
    begin
        seed_a   = s_tuser ? ({{(WORD_W-LEN_W){1'b0}}, in_length} ^ HASH_K1) : lane_a_reg;
        seed_b   = s_tuser ? HASH_K2 : lane_b_reg;
        msg_live = s_tuser || open_reg;
        finish_b = mul_product[WORD_W-1:0] + tmp_hi_reg;
    end

    // chunk sequencer
    always_comb
    begin
        state_next   = state_reg;
        lane_a_next  = lane_a_reg;
        lane_b_next  = lane_b_reg;
        open_next    = open_reg;
        last_next    = last_reg;
        round_next   = round_reg;
        data_lo_next = data_lo_reg;
        data_hi_next = data_hi_reg;
        tmp_lo_next  = tmp_lo_reg;
        tmp_hi_next  = tmp_hi_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && msg_live)
                begin
                    data_lo_next = in_low;
                    data_hi_next = in_high;
                    last_next    = s_tlast;
                    round_next   = 1'b0;
                    open_next    = !s_tlast;
                    lane_a_next  = seed_a;
                    lane_b_next  = seed_b;
                    if (in_count[COUNT_W-1])
                    begin
                        state_next = S_CA_GO;
                    end
                    else
                    begin
                        if (s_tlast)
                        begin
                            lane_a_next = seed_a ^ (in_count[3] ? in_low : '0);
                            lane_b_next = seed_b ^ fold_word;
                            state_next  = S_FA_GO;
                        end
                    end
                end
            end
            S_CA_GO:   state_next = S_CA_WAIT;
            S_CA_WAIT:
            begin
                if (mul_stat.done)
                begin
                    lane_a_next = byte_rev(mul_product[WORD_W-1:0]);
                    state_next  = S_CB_GO;
                end
            end
            S_CB_GO:   state_next = S_CB_WAIT;
            S_CB_WAIT:
            begin
                if (mul_stat.done)
                begin
                    lane_b_next = byte_rev(mul_product[WORD_W-1:0]);
                    state_next  = last_reg ? S_FA_GO : S_IDLE;
                end
            end
            S_FA_GO:   state_next = S_FA_WAIT;
            S_FA_WAIT:
            begin
                if (mul_stat.done)
                begin
                    tmp_lo_next = mul_product[WORD_W-1:0];
                    tmp_hi_next = mul_product[PROD_W-1:WORD_W];
                    state_next  = S_FB_GO;
                end
            end
            S_FB_GO:   state_next = S_FB_WAIT;
            S_FB_WAIT:
            begin
                if (mul_stat.done)
                begin
                    lane_b_next = finish_b;
                    lane_a_next = tmp_lo_reg ^ finish_b;
                    round_next  = 1'b1;
                    state_next  = round_reg ? S_OUT : S_FA_GO;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = lane_a_reg ^ {{HALF_W{1'b0}}, lane_a_reg[WORD_W-1:HALF_W]};
                    state_next   = S_IDLE;
                end
            end
            default:   state_next = S_IDLE;
        endcase
    end

    // control and lane state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            lane_a_reg  <= '0;
            lane_b_reg  <= '0;
            open_reg    <= 1'b0;
            last_reg    <= 1'b0;
            round_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            lane_a_reg  <= lane_a_next;
            lane_b_reg  <= lane_b_next;
            open_reg    <= open_next;
            last_reg    <= last_next;
            round_reg   <= round_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        data_lo_reg <= data_lo_next;
        data_hi_reg <= data_hi_next;
        tmp_lo_reg  <= tmp_lo_next;
        tmp_hi_reg  <= tmp_hi_next;
        m_data_reg  <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // the input side never opens while the multiplier is working
    a_idle_mul_free: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !mul_stat.busy)
        else $error("input ready while multiplier busy");

    // a product only completes while the sequencer waits for one
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        mul_stat.done |-> (state_reg == S_CA_WAIT || state_reg == S_CB_WAIT ||
                           state_reg == S_FA_WAIT || state_reg == S_FB_WAIT))
        else $error("multiplier done outside a wait step");

    // a new result only comes out of the output step
    a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg) == S_OUT)
        else $error("result raised outside the output step");

    // the output step with a free register always hands over
    a_out_handover: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && out_free) |=> (m_tvalid && state_reg == S_IDLE))
        else $error("output step did not hand over result");

endmodule

### design/tlmh64_mul.sv
// Iterative 64x64 to 128-bit multiplier built around one 32x32 multiplier.
// Four partial products are formed one per cycle and summed into an accumulator.
// Depends on tlmh64_pkg.
module tlmh64_mul (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tlmh64_pkg::mul_req_t req,
    output tlmh64_pkg::mul_stat_t stat,
    output logic [127:0]         product
);
    import tlmh64_pkg::*;

    localparam logic [2:0] LAST_STEP = 3'd4;

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [2:0]          step_reg, step_next;
    logic [WORD_W-1:0]   a_reg, a_next;
    logic [WORD_W-1:0]   b_reg, b_next;
    logic [WORD_W-1:0]   pp_reg, pp_next;
    logic [1:0]          pp_shift_reg, pp_shift_next;
    logic                pp_valid_reg, pp_valid_next;
    logic [PROD_W-1:0]   acc_reg, acc_next;
    logic [HALF_W-1:0]   a_half;
    logic [HALF_W-1:0]   b_half;
    logic [PROD_W-1:0]   pp_aligned;

    // operand halves picked by the step: a0b0, a0b1, a1b0, a1b1
    always_comb
    begin
        a_half = step_reg[1] ? a_reg[WORD_W-1:HALF_W] : a_reg[HALF_W-1:0];
        b_half = step_reg[0] ? b_reg[WORD_W-1:HALF_W] : b_reg[HALF_W-1:0];
    end

    // align the registered partial product to its weight
    always_comb
    begin
        case (pp_shift_reg)
            2'd0:    pp_aligned = {{(PROD_W-WORD_W){1'b0}}, pp_reg};
            2'd1:    pp_aligned = {{HALF_W{1'b0}}, pp_reg, {HALF_W{1'b0}}};
            default: pp_aligned = {pp_reg, {WORD_W{1'b0}}};
        endcase
    end

    // step sequencing and accumulation
    always_comb
    begin
        busy_next     = busy_reg;
        done_next     = 1'b0;
        step_next     = step_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        pp_next       = pp_reg;
        pp_shift_next = pp_shift_reg;
        pp_valid_next = 1'b0;
        acc_next      = acc_reg;
        if (pp_valid_reg)
        begin
            acc_next = acc_reg + pp_aligned;
        end
        if (req.start)
        begin
            a_next    = req.a;
            b_next    = req.b;
            acc_next  = '0;
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (step_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                pp_next       = {{HALF_W{1'b0}}, a_half} * {{HALF_W{1'b0}}, b_half};
                pp_shift_next = {1'b0, step_reg[1]} + {1'b0, step_reg[0]};
                pp_valid_next = 1'b1;
                step_next     = step_reg + 3'd1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            done_reg     <= 1'b0;
            step_reg     <= '0;
            pp_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg     <= busy_next;
            done_reg     <= done_next;
            step_reg     <= step_next;
            pp_valid_reg <= pp_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        a_reg        <= a_next;
        b_reg        <= b_next;
        pp_reg       <= pp_next;
        pp_shift_reg <= pp_shift_next;
        acc_reg      <= acc_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign product   = acc_reg;

endmodule

### design/tlmh64_fold.sv
// Tail word builder for a short last chunk of 1 to 15 bytes.
// Gathers the 4, 2 and 1 byte groups that follow the optional 8-byte word.
// Depends on tlmh64_pkg.
module tlmh64_fold (
    input  logic [63:0] data_low,
    input  logic [63:0] data_high,
    input  logic [3:0]  count,
    output logic [63:0] word
);
    import tlmh64_pkg::*;

    logic [PROD_W-1:0] chunk;
    logic [3:0]        off2;
    logic [3:0]        off1;
    logic [31:0]       group4;
    logic [15:0]       group2;
    logic [7:0]        group1;
    logic [WORD_W-1:0] w4;
    logic [WORD_W-1:0] w2;

    assign chunk = {data_high, data_low};

    // byte offsets of the two- and one-byte groups
    always_comb
    begin
        off2 = {count[3], count[2], 2'b00};
        off1 = off2 + {1'b0, count[1], 1'b0, 1'b0} - {2'b00, count[1], 1'b0};
    end

    // pick the groups out of the chunk
    always_comb
    begin
        group4 = count[3] ? data_high[31:0] : data_low[31:0];
        group2 = chunk[{off2, 3'b000} +: 16];
        group1 = chunk[{off1, 3'b000} +: 8];
    end

    // fold the groups together, most significant first
    always_comb
    begin
        w4 = count[2] ? {{HALF_W{1'b0}}, group4} : '0;
        w2 = count[1] ? {w4[WORD_W-17:0], group2} : w4;
        word = count[0] ? {w2[WORD_W-9:0], group1} : w2;
    end

endmodule

### tb/hash_checker.sv
// Scoreboard for the two-lane multiply hash: watches both stream channels,
// predicts each hash from the accepted chunks and compares the results.
// Depends on tlmh64_pkg for the hash constants and the input width.
module hash_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    // message_length, data_low, data_high, byte_count, 3 zero bits
    input  logic [tlmh64_pkg::IN_DATA_W-1:0] s_tdata,
    // first_chunk
    input  logic                             s_tuser,
    input  logic                             s_tlast,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    // hash_value
    input  logic [63:0]                      m_tdata,
    output int                               errors,
    output int                               pending
);

    import tlmh64_pkg::*;

    // input transfer layout, highest field first
    typedef struct packed {
        logic [2:0]  pad;
        logic [4:0]  byte_count;
        logic [63:0] data_high;
        logic [63:0] data_low;
        logic [31:0] message_length;
    } chunk_t;

    logic [63:0] lane_a;
    logic [63:0] lane_b;
    bit          msg_open;
    logic [63:0] hash_expected[$];
    int          fail_total;

    initial
    begin
        errors     = 0;
        pending    = 0;
        fail_total = 0;
        lane_a     = '0;
        lane_b     = '0;
        msg_open   = 1'b0;
    end

    // reverse the byte order of a lane word
    function automatic logic [63:0] swap_bytes(input logic [63:0] x);
        return {x[7:0], x[15:8], x[23:16], x[31:24],
                x[39:32], x[47:40], x[55:48], x[63:56]};
    endfunction

    // fold a 1..15 byte tail into the lanes: 8, then 4, 2 and 1 bytes
    function automatic void fold_short_tail(input logic [63:0] lo, input logic [63:0] hi,
                                            input logic [4:0] n);
        logic [127:0] bytes;
        logic [63:0]  word;
        int           off;
        bytes = {hi, lo};
        word  = '0;
        off   = 0;
        if (n[3])
        begin
            lane_a = lane_a ^ lo;
            off    = 8;
        end
        if (n[2])
        begin
            word = {32'b0, bytes[8*off +: 32]};
            off  = off + 4;
        end
        if (n[1])
        begin
            word = (word << 16) | {48'b0, bytes[8*off +: 16]};
            off  = off + 2;
        end
        if (n[0])
            word = (word << 8) | {56'b0, bytes[8*off +: 8]};
        lane_b = lane_b ^ word;
    endfunction

    // one finishing round: wide product of lane a, carry high half into lane b
    function automatic void finish_round();
        logic [127:0] prod;
        prod   = {64'b0, lane_a} * {64'b0, HASH_K1};
        lane_a = prod[63:0];
        lane_b = lane_b * HASH_K2 + prod[127:64];
        lane_a = lane_a ^ lane_b;
    endfunction

    // advance the lanes by one chunk; returns 1 with the hash on a closing chunk
    function automatic bit hash_chunk(input chunk_t c, input bit first, input bit last,
                                      output logic [63:0] hash);
        logic [4:0] n;
        hash = '0;
        n    = (c.byte_count > 5'd16) ? 5'd16 : c.byte_count;
        if (first)
        begin
            lane_a   = {32'b0, c.message_length} ^ HASH_K1;
            lane_b   = HASH_K2;
            msg_open = 1'b1;
        end
        if (!msg_open)
            return 1'b0;
        if (n == 5'd16)
        begin
            lane_a = swap_bytes((lane_a ^ c.data_low) * HASH_K1);
            lane_b = swap_bytes((lane_b ^ c.data_high) * HASH_K2);
        end
        else if (last && n != 5'd0)
            fold_short_tail(c.data_low, c.data_high, n);
        if (!last)
            return 1'b0;
        finish_round();
        finish_round();
        hash     = lane_a ^ (lane_a >> 32);
        msg_open = 1'b0;
        return 1'b1;
    endfunction

    // predict on input transfers, compare on output transfers
    always @(posedge clk)
    begin
        logic [63:0] hash;
        logic [63:0] want;
        if (!rst_n)
        begin
            lane_a   = '0;
            lane_b   = '0;
            msg_open = 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                if (hash_chunk(chunk_t'(s_tdata), s_tuser, s_tlast, hash))
                    hash_expected.push_back(hash);
            end
            if (m_tvalid && m_tready)
            begin
                if (hash_expected.size() == 0)
                begin
                    $display("%0t: unexpected hash %h, none outstanding", $time, m_tdata);
                    fail_total++;
                end
                else
                begin
                    want = hash_expected.pop_front();
                    if (m_tdata !== want)
                    begin
                        $display("%0t: hash_value mismatch, expected %h, actual %h",
                                 $time, want, m_tdata);
                        fail_total++;
                    end
                end
            end
        end
        errors  <= fail_total;
        pending <= hash_expected.size();
    end

endmodule

### tb/testbench.sv
// Top of the two-lane multiply hash testbench: clock, reset and stimulus.
// Drives message chunks into two_lane_multiply_hash64 and reads the verdict
// from hash_checker; depends on tlmh64_pkg.
module testbench;

    localparam int PHASE_CHUNKS = 306;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 120;

    logic                             clk;
    logic                             rst_n;
    logic                             s_tvalid;
    logic                             s_tready;
    logic [tlmh64_pkg::IN_DATA_W-1:0] s_tdata;
    logic                             s_tuser;
    logic                             s_tlast;
    logic                             m_tvalid;
    logic                             m_tready;
    logic [63:0]                      m_tdata;
    int                               errors;
    int                               pending;

    int idle_pct;
    int stall_pct;
    int hold_asks;
    int holds_done;
    int chunks_sent;

    two_lane_multiply_hash64 i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    hash_checker i_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .errors   (errors),
        .pending  (pending)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // receiver: random stalls, plus a long hold-off when asked
    initial
    begin
        m_tready   = 1'b0;
        holds_done = 0;
        forever
        begin
            @(posedge clk);
            if (hold_asks != holds_done)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                holds_done++;
            end
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // offer one chunk after a random gap and wait for its transfer
    task automatic send_chunk(input bit first, input bit last, input logic [31:0] len,
                              input logic [63:0] lo, input logic [63:0] hi,
                              input logic [4:0] cnt);
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= first;
        s_tlast  <= last;
        s_tdata  <= {3'b000, cnt, hi, lo, len};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // well-formed message with random content; complete=0 leaves it unfinished
    task automatic send_message(input bit complete);
        int          chunks;
        int          r;
        bit          last;
        logic [4:0]  cnt;
        logic [31:0] len;
        chunks = ($urandom_range(9) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
        len    = ($urandom_range(2) == 0) ? $urandom : 32'(chunks * 16 - $urandom_range(15));
        for (int i = 0; i < chunks; i++)
        begin
            last = complete && (i == chunks - 1);
            r    = $urandom_range(99);
            if (last)
                cnt = (r < 85) ? 5'($urandom_range(16)) : 5'($urandom_range(17, 31));
            else
                cnt = (r < 90) ? 5'd16 : 5'($urandom_range(15));
            send_chunk(i == 0, last, len, rand_word(), rand_word(), cnt);
            chunks_sent++;
        end
    endtask

    // reset, directed chunks, random phases, drain and verdict
    initial
    begin
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = 1'b0;
        s_tlast     = 1'b0;
        idle_pct    = 0;
        stall_pct   = 0;
        hold_asks   = 0;
        chunks_sent = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // single-chunk messages: full, empty, longest tail, widest length
        send_chunk(1'b1, 1'b1, 32'd16, '1, '1, 5'd16);
        send_chunk(1'b1, 1'b1, 32'd0, '0, '0, 5'd0);
        send_chunk(1'b1, 1'b1, 32'd15, '1, '1, 5'd15);
        send_chunk(1'b1, 1'b1, 32'hffff_ffff, 64'h0123_4567_89ab_cdef,
                   64'hfedc_ba98_7654_3210, 5'd1);
        // tails of one power of two each
        send_chunk(1'b1, 1'b1, 32'd2, 64'h8899_aabb_ccdd_eeff, 64'h0011_2233_4455_6677, 5'd2);
        send_chunk(1'b1, 1'b1, 32'd4, 64'h8899_aabb_ccdd_eeff, 64'h0011_2233_4455_6677, 5'd4);
        send_chunk(1'b1, 1'b1, 32'd8, 64'h8899_aabb_ccdd_eeff, 64'h0011_2233_4455_6677, 5'd8);
        // oversized counts act as full chunks
        send_chunk(1'b1, 1'b1, 32'd16, 64'h1111_2222_3333_4444, 64'h5555_6666_7777_8888, 5'd31);
        send_chunk(1'b1, 1'b1, 32'd16, 64'h1111_2222_3333_4444, 64'h5555_6666_7777_8888, 5'd17);
        // no message open: dropped
        send_chunk(1'b0, 1'b1, 32'd16, '1, '1, 5'd16);
        send_chunk(1'b0, 1'b0, 32'd16, '1, '1, 5'd16);
        // three-chunk message
        send_chunk(1'b1, 1'b0, 32'd40, 64'hdead_beef_0bad_f00d, 64'h0f0f_0f0f_f0f0_f0f0, 5'd16);
        send_chunk(1'b0, 1'b0, 32'd40, 64'h0f0f_0f0f_f0f0_f0f0, 64'hdead_beef_0bad_f00d, 5'd16);
        send_chunk(1'b0, 1'b1, 32'd40, 64'h0123_4567_89ab_cdef, 64'hffff_0000_ffff_0000, 5'd8);
        // restart while a message is open
        send_chunk(1'b1, 1'b0, 32'd32, 64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555, 5'd16);
        send_chunk(1'b1, 1'b1, 32'd16, 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa, 5'd16);
        // short chunk that is not the last one
        send_chunk(1'b1, 1'b0, 32'd21, 64'hcafe_babe_cafe_babe, 64'h1234_5678_9abc_def0, 5'd5);
        send_chunk(1'b0, 1'b1, 32'd21, 64'h1234_5678_9abc_def0, 64'hcafe_babe_cafe_babe, 5'd16);
        // empty last chunk after a full one
        send_chunk(1'b1, 1'b0, 32'd16, 64'h7777_7777_7777_7777, 64'h9999_9999_9999_9999, 5'd16);
        send_chunk(1'b0, 1'b1, 32'd16, '1, '1, 5'd0);

        // random phases: no idling, sender idle, receiver stall, both
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = 49;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 49;
                end
                default:
                begin
                    idle_pct  = 19;
                    stall_pct = 19;
                end
            endcase
            while (chunks_sent < (phase + 1) * PHASE_CHUNKS)
            begin
                // long receiver hold-off so the output backs up into the input
                if (phase == 0 && hold_asks == 0 && chunks_sent > 100)
                    hold_asks = 1;
                case ($urandom_range(19))
                    0: send_message(1'b0);
                    1: send_chunk(1'($urandom_range(1)), 1'($urandom_range(1)), $urandom,
                                  rand_word(), rand_word(), 5'($urandom_range(31)));
                    default: send_message(1'b1);
                endcase
            end
        end

        // drain
        s_tvalid <= 1'b0;
        stall_pct = 0;
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
